[hw/rtl/rle_pd_pkg.sv]
package rle_pd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PB_W       = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned SPACE_W    = 32;
  localparam int unsigned REP_W      = 8;
  localparam int unsigned LIT_W      = 10;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // A truncated run leaves fewer than 128 * 4 bytes, so the dividend is 9 bits wide.
  localparam int unsigned DIV_W      = 9;
  localparam int unsigned DIV_CNT_W  = 4;

  localparam logic CFG_PIXEL_BYTES  = 1'b0;
  localparam logic CFG_OUT_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXEL,
    PH_LITERAL,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_DIV,
    SQ_EMIT
  } seq_t;

  // 0 acts as 1, 5..7 act as 4
  function automatic logic [PB_W-1:0] eff_pb(input logic [PB_W-1:0] raw);
    logic [PB_W-1:0] r;
    if (raw == '0) begin
      r = PB_W'(1);
    end else if (raw > PB_W'(4)) begin
      r = PB_W'(4);
    end else begin
      r = raw;
    end
    return r;
  endfunction

endpackage

[hw/rtl/rle_pixel_decompressor.sv]
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: in_byte; tuser: stream_start
// out_     out  out_tvalid/out_tready  tdata: unit_value, unit_bytes, repeat_res;
//                                      tuser: output_full
// cfg_     in   cfg_valid/cfg_ready    cfg_addr: register index; cfg_data: value
//
// Header, literal and pixel bytes are taken while the divider is idle and the
// output slot is free. A run whose repeat count has to be cut to the remaining
// space goes through the shift-subtract divider: one quotient bit per cycle.
// Reset is synchronous; all decode state returns to "header expected", no space.
// A result waiting in the output register while out_tready is low holds in_tready
// low, so no byte is taken until that result leaves.
module rle_pixel_decompressor
  import rle_pd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] in_byte
  input  logic                  in_tuser,   // [0] stream_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] unit_value, [34:32] unit_bytes, [42:35] repeat_res, [47:43] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] output_full
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_addr,
  input  logic [SPACE_W-1:0]    cfg_data
);

  // configuration
  logic [PB_W-1:0]    pb_cfg_r;
  logic [SPACE_W-1:0] cap_r;

  // decode state
  phase_t              phase_r, phase_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [VALUE_W-1:0]  asm_r, asm_nxt;
  logic [6:0]          hdr_r, hdr_nxt;
  logic [LIT_W-1:0]    lit_r, lit_nxt;
  logic [SPACE_W-1:0]  space_r, space_nxt;

  // sequencer and divider
  seq_t                seq_r, seq_nxt;
  logic [DIV_W-1:0]    div_dvd_r, div_dvd_nxt;
  logic [DIV_W-1:0]    div_q_r, div_q_nxt;
  logic [PB_W-1:0]     div_rem_r, div_rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [PB_W-1:0]     out_bytes_r, out_bytes_nxt;
  logic [REP_W-1:0]    out_rep_r, out_rep_nxt;
  logic                out_full_r, out_full_nxt;

  logic [PB_W-1:0]     pb;
  logic                slot_free;
  logic                in_fire;
  logic                out_load;
  logic                div_start;
  logic                div_last;

  // step intermediates
  phase_t              ph;
  logic [1:0]          idx;
  logic [VALUE_W-1:0]  asm_v;
  logic [LIT_W-1:0]    lit;
  logic [SPACE_W-1:0]  sp;
  logic [8:0]          lit_hdr_cnt;
  logic [11:0]         lit_len;
  logic [REP_W-1:0]    rep_full;
  logic [10:0]         run_prod;
  logic [SPACE_W-1:0]  sp_after;
  logic [3:0]          div_trial;
  logic                div_ge;

  assign pb        = eff_pb(pb_cfg_r);
  assign slot_free = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign div_last  = (div_cnt_r == DIV_CNT_W'(1));

  assign div_trial = {div_rem_r, div_dvd_r[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, pb});

  // sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SQ_IDLE: begin
        if (div_start) begin
          seq_nxt = SQ_DIV;
        end
      end
      SQ_DIV: begin
        if (div_last) begin
          seq_nxt = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if (div_q_r == '0 || slot_free) begin
          seq_nxt = SQ_IDLE;
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  // decode datapath and outputs
  always_comb begin
    in_tready     = (seq_r == SQ_IDLE) && slot_free;
    cfg_ready     = 1'b1;

    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    asm_nxt       = asm_r;
    hdr_nxt       = hdr_r;
    lit_nxt       = lit_r;
    space_nxt     = space_r;
    div_dvd_nxt   = div_dvd_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_value_nxt = out_value_r;
    out_bytes_nxt = out_bytes_r;
    out_rep_nxt   = out_rep_r;
    out_full_nxt  = out_full_r;

    ph       = in_tuser ? PH_HEADER : phase_r;
    idx      = in_tuser ? 2'd0 : idx_r;
    asm_v    = in_tuser ? '0 : asm_r;
    lit      = in_tuser ? '0 : lit_r;
    sp       = in_tuser ? cap_r : space_r;

    lit_hdr_cnt = 9'(9'd256 - {1'b0, in_tdata});
    lit_len     = 12'({3'b0, lit_hdr_cnt} * {9'b0, pb});
    rep_full    = REP_W'({1'b0, hdr_r} + 8'd1);
    run_prod    = 11'({3'b0, rep_full} * {8'b0, pb});
    sp_after    = sp - {21'b0, run_prod};

    if (in_fire) begin
      phase_nxt = ph;
      idx_nxt   = idx;
      asm_nxt   = asm_v;
      lit_nxt   = lit;
      space_nxt = sp;
      if (ph == PH_DONE || sp == '0) begin
        phase_nxt = PH_DONE;
      end else begin
        case (ph)
          PH_HEADER: begin
            if (!in_tdata[7]) begin
              hdr_nxt   = in_tdata[6:0];
              idx_nxt   = 2'd0;
              asm_nxt   = '0;
              phase_nxt = PH_PIXEL;
            end else begin
              if ({20'b0, lit_len} > sp) begin
                lit_nxt = sp[LIT_W-1:0];
              end else begin
                lit_nxt = LIT_W'(lit_len);
              end
              phase_nxt = PH_LITERAL;
            end
          end
          PH_PIXEL: begin
            asm_nxt = asm_v | ({24'b0, in_tdata} << {idx, 3'b000});
            if (({1'b0, idx} + 3'd1) < pb) begin
              idx_nxt = 2'(idx + 2'd1);
            end else begin
              idx_nxt = 2'd0;
              if ({21'b0, run_prod} <= sp) begin
                space_nxt     = sp_after;
                phase_nxt     = (sp_after == '0) ? PH_DONE : PH_HEADER;
                out_load      = 1'b1;
                out_value_nxt = asm_v | ({24'b0, in_tdata} << {idx, 3'b000});
                out_bytes_nxt = pb;
                out_rep_nxt   = rep_full;
                out_full_nxt  = (sp_after == '0);
              end else begin
                // space below a full run: quotient space / pb, remainder stays
                div_start   = 1'b1;
                div_dvd_nxt = sp[DIV_W-1:0];
                div_q_nxt   = '0;
                div_rem_nxt = '0;
                div_cnt_nxt = DIV_CNT_W'(DIV_W);
              end
            end
          end
          PH_LITERAL: begin
            space_nxt = sp - SPACE_W'(1);
            if (lit != '0) begin
              lit_nxt = lit - LIT_W'(1);
            end
            if (sp == SPACE_W'(1)) begin
              phase_nxt = PH_DONE;
            end else if (lit <= LIT_W'(1)) begin
              phase_nxt = PH_HEADER;
            end
            out_load      = 1'b1;
            out_value_nxt = {24'b0, in_tdata};
            out_bytes_nxt = PB_W'(1);
            out_rep_nxt   = REP_W'(1);
            out_full_nxt  = (sp == SPACE_W'(1));
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end

    if (seq_r == SQ_DIV) begin
      div_rem_nxt = div_ge ? PB_W'(div_trial - {1'b0, pb}) : div_trial[PB_W-1:0];
      div_q_nxt   = {div_q_r[DIV_W-2:0], div_ge};
      div_dvd_nxt = {div_dvd_r[DIV_W-2:0], 1'b0};
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end

    if (seq_r == SQ_EMIT) begin
      if (div_q_r == '0) begin
        phase_nxt = PH_DONE;
      end else if (slot_free) begin
        space_nxt     = {29'b0, div_rem_r};
        phase_nxt     = (div_rem_r == '0) ? PH_DONE : PH_HEADER;
        out_load      = 1'b1;
        out_value_nxt = asm_r;
        out_bytes_nxt = pb;
        out_rep_nxt   = div_q_r[REP_W-1:0];
        out_full_nxt  = (div_rem_r == '0);
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_tvalid = out_valid_r;
    out_tdata  = {5'b0, out_rep_r, out_bytes_r, out_value_r};
    out_tuser  = out_full_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_cfg_r    <= PB_W'(1);
      cap_r       <= '0;
      phase_r     <= PH_HEADER;
      idx_r       <= '0;
      asm_r       <= '0;
      hdr_r       <= '0;
      lit_r       <= '0;
      space_r     <= '0;
      seq_r       <= SQ_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_PIXEL_BYTES:  pb_cfg_r <= cfg_data[PB_W-1:0];
          CFG_OUT_CAPACITY: cap_r    <= cfg_data;
          default:          cap_r    <= cap_r;
        endcase
      end
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      asm_r       <= asm_nxt;
      hdr_r       <= hdr_nxt;
      lit_r       <= lit_nxt;
      space_r     <= space_nxt;
      seq_r       <= seq_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_dvd_r   <= div_dvd_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    out_value_r <= out_value_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_rep_r   <= out_rep_nxt;
    out_full_r  <= out_full_nxt;
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> seq_r == SQ_IDLE)
    else $error("input taken while divider busy");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SQ_DIV |-> div_cnt_r != '0 && div_cnt_r <= DIV_CNT_W'(DIV_W))
    else $error("divider step count out of range");

  a_full_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_full_nxt) |=> phase_r == PH_DONE)
    else $error("capacity used up but decoder not done");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[42:35] != '0 && out_tdata[34:32] != '0)
    else $error("result with zero repeat or zero bytes");
`endif

endmodule
